/* src/mmiu_pkg.sv */
// Package with the types and constants shared by the machine-mode interrupt unit.
package mmiu_pkg;

	localparam int unsigned XLEN = 32;

	typedef logic [XLEN-1:0] word_t;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_CHECK = 2'd2,
		KIND_TRAP  = 2'd3
	} kind_t;

	typedef logic [2:0] sel_t;

	localparam sel_t SEL_MSTATUS = 3'd0;
	localparam sel_t SEL_MIE     = 3'd1;
	localparam sel_t SEL_MIP     = 3'd2;
	localparam sel_t SEL_MEPC    = 3'd3;
	localparam sel_t SEL_MCAUSE  = 3'd4;
	localparam sel_t SEL_MTVEC   = 3'd5;

	localparam int unsigned MSTATUS_MIE_BIT  = 3;
	localparam int unsigned MSTATUS_MPIE_BIT = 7;
	localparam int unsigned MSTATUS_MPP_LO   = 11;
	localparam int unsigned MSTATUS_MPP_HI   = 12;
	localparam int unsigned MIP_MTIP_BIT     = 7;
	localparam int unsigned MIP_MEIP_BIT     = 11;

	localparam word_t CAUSE_M_TIMER = 32'h8000_0007;
	localparam word_t CAUSE_M_EXT   = 32'h8000_000b;

	typedef struct packed {
		kind_t kind;
		sel_t  reg_select;
		word_t write_value;
		logic  timer_tick;
		logic  core_running;
		word_t exc_cause;
		word_t trap_pc;
	} item_t;

	typedef struct packed {
		word_t read_value;
		logic  irq_valid;
		word_t irq_cause;
		logic  sync_needed;
		word_t handler_address;
	} result_t;

endpackage

/* src/mmiu_stream_if.sv */
// Valid/ready channel interface carrying one payload beat of a chosen type.
interface mmiu_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/mmiu_csr_file.sv */
// Machine-mode trap registers with the read, write, interrupt check and trap logic.
module mmiu_csr_file (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  mmiu_pkg::item_t  item,
	output mmiu_pkg::result_t res
);
	import mmiu_pkg::*;

	word_t status_q, enable_q, pending_q, epc_q, cause_q, vector_q;
	word_t status_d, enable_d, pending_d, epc_d, cause_d, vector_d;
	word_t pend_tick;
	word_t active;

	always_comb begin
		status_d  = status_q;
		enable_d  = enable_q;
		pending_d = pending_q;
		epc_d     = epc_q;
		cause_d   = cause_q;
		vector_d  = vector_q;
		res       = '0;

		// Pending bits as they stand once a timer tick has been folded in.
		pend_tick = pending_q;
		if (item.core_running && item.timer_tick) begin
			pend_tick[MIP_MTIP_BIT] = 1'b1;
		end
		active = pend_tick & enable_q;

		case (item.kind)
			KIND_READ: begin
				case (item.reg_select)
					SEL_MSTATUS: res.read_value = status_q;
					SEL_MIE:     res.read_value = enable_q;
					SEL_MIP:     res.read_value = pending_q;
					SEL_MEPC:    res.read_value = epc_q;
					SEL_MCAUSE:  res.read_value = cause_q;
					SEL_MTVEC:   res.read_value = vector_q;
					default:     res.read_value = '0;
				endcase
			end
			KIND_WRITE: begin
				case (item.reg_select)
					SEL_MSTATUS: status_d  = item.write_value;
					SEL_MIE:     enable_d  = item.write_value;
					SEL_MIP:     pending_d = item.write_value;
					SEL_MEPC:    epc_d     = item.write_value;
					SEL_MCAUSE:  cause_d   = item.write_value;
					SEL_MTVEC:   vector_d  = item.write_value;
					default:     ;
				endcase
			end
			KIND_CHECK: begin
				if (item.core_running) begin
					pending_d       = pend_tick;
					res.sync_needed = item.timer_tick;
					if (status_q[MSTATUS_MIE_BIT]) begin
						if (active[MIP_MTIP_BIT]) begin
							res.irq_valid   = 1'b1;
							res.irq_cause   = CAUSE_M_TIMER;
							res.sync_needed = 1'b1;
						end else if (active[MIP_MEIP_BIT]) begin
							res.irq_valid   = 1'b1;
							res.irq_cause   = CAUSE_M_EXT;
							res.sync_needed = 1'b1;
						end
					end
				end
			end
			KIND_TRAP: begin
				if (item.exc_cause == CAUSE_M_TIMER) begin
					pending_d[MIP_MTIP_BIT] = 1'b0;
				end else if (item.exc_cause == CAUSE_M_EXT) begin
					pending_d[MIP_MEIP_BIT] = 1'b0;
				end
				epc_d   = item.trap_pc;
				cause_d = item.exc_cause;
				status_d[MSTATUS_MPIE_BIT] = status_q[MSTATUS_MIE_BIT];
				status_d[MSTATUS_MIE_BIT]  = 1'b0;
				status_d[MSTATUS_MPP_HI:MSTATUS_MPP_LO] = 2'b11;
				res.handler_address = vector_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			enable_q  <= '0;
			pending_q <= '0;
			epc_q     <= '0;
			cause_q   <= '0;
			vector_q  <= '0;
		end else if (fire) begin
			status_q  <= status_d;
			enable_q  <= enable_d;
			pending_q <= pending_d;
			epc_q     <= epc_d;
			cause_q   <= cause_d;
			vector_q  <= vector_d;
		end
	end

endmodule

/* src/machine_mode_interrupt_unit.sv */
// Top level of the machine-mode interrupt unit: input stage, trap registers, result stage.
//
// Usage: each beat on req carries one operation on the machine-mode trap
// registers (mstatus, mie, mip, mepc, mcause, mtvec): a register read, a
// register write, an interrupt check or a trap entry. Exactly one beat leaves
// on rsp for every beat taken on req, in the same order.
// Path: a request beat is registered in the input stage, processed by the trap
// register logic as it leaves that stage and lands in the result register,
// which drives rsp.valid and rsp.data.
// Throughput: one beat per cycle. The only limit is the result register: the
// input stage advances whenever the result register is empty or is being
// drained in the same cycle.
// Stalls: when the receiver holds rsp.ready low, the result stays put and the
// input stage holds one more beat; req.ready then drops until rsp drains.
// Register state changes only as a beat moves from the input stage into the
// result register, so stalling never duplicates or loses an update.
// Reset: arst_n clears the valid flags of both stages and all six trap registers to zero.
module machine_mode_interrupt_unit (
	input  logic          clk,
	input  logic          arst_n,
	mmiu_stream_if.sink   req,
	mmiu_stream_if.source rsp
);
	import mmiu_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    advance;

	// The input stage moves forward when the result register can take its beat.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload stage needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// The trap registers commit the beat in the same cycle that its result is captured.
	mmiu_csr_file u_csr_file (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

endmodule

/* src/mmiu_checker.sv */
// Port-level assertions for the machine-mode interrupt unit, bound to its top level.
module mmiu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input mmiu_pkg::result_t rsp_data
);
	import mmiu_pkg::*;

	// A reported interrupt always carries a known cause and asks for a resync.
	a_irq_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.irq_valid |->
			rsp_data.sync_needed &&
			(rsp_data.irq_cause == CAUSE_M_TIMER || rsp_data.irq_cause == CAUSE_M_EXT))
		else $error("interrupt reported without a valid cause or resync");

	a_no_irq_no_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.irq_valid |-> rsp_data.irq_cause == '0)
		else $error("interrupt cause set without an interrupt");

	// A trap result drives the handler address only.
	a_trap_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.handler_address != '0 |->
			rsp_data.read_value == '0 && !rsp_data.irq_valid && !rsp_data.sync_needed)
		else $error("trap result mixed with other result fields");

	// Requests are only held off while a result waits on the receiver.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without an output stall");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result beat changed");

endmodule

bind machine_mode_interrupt_unit mmiu_checker u_mmiu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

/* dv/tb_machine_mode_interrupt_unit.sv */
// Self-checking testbench for the machine-mode interrupt unit: directed table, then random beats.
module tb_machine_mode_interrupt_unit;

	import mmiu_pkg::*;

	// Register selects that decode to no register at all.
	localparam sel_t SEL_NONE_LO = 3'd6;
	localparam sel_t SEL_NONE_HI = 3'd7;

	localparam word_t ALL_ONES  = 32'hffff_ffff;
	localparam word_t MIE_MASK  = word_t'(1) << MSTATUS_MIE_BIT;
	localparam word_t MTIP_MASK = word_t'(1) << MIP_MTIP_BIT;
	localparam word_t MEIP_MASK = word_t'(1) << MIP_MEIP_BIT;

	localparam int RANDOM_ITEMS     = 1400;
	localparam int DIRECTED_ITEMS   = 26;
	// Below this many beats left to send, neither side idles any more.
	localparam int QUIET_TAIL_ITEMS = 150;
	// The long receiver hold-off starts after this many results have drained.
	localparam int HOLD_OFF_AT      = 400;
	localparam int HOLD_OFF_CYCLES  = 300;
	// Cycles without any beat on either side before the run is declared hung.
	localparam int WATCHDOG_LIMIT   = 5000;
	// Cycles allowed after the last expected result for stray beats to show up.
	localparam int TAIL_CYCLES      = 8;

	typedef struct {
		item_t   item;
		bit      fixed;   // golden result typed into the table
		result_t golden;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mmiu_stream_if #(.T(item_t))   req_if ();
	mmiu_stream_if #(.T(result_t)) rsp_if ();

	machine_mode_interrupt_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the six trap registers, advanced once per accepted request beat.
	word_t shadow_status;
	word_t shadow_enable;
	word_t shadow_pending;
	word_t shadow_epc;
	word_t shadow_cause;
	word_t shadow_vector;

	stim_row_t directed_rows [0:DIRECTED_ITEMS-1];
	stim_row_t pending_beats [$];
	result_t   expected_responses [$];

	stim_row_t cur_row;
	result_t   want;
	int        total_items;
	int        items_accepted;
	int        results_seen;
	int        errors;
	int        gap_left;
	int        stall_left;
	int        hold_left;
	int        idle_cycles;
	bit        quiet_tail;

	// Works out the response to one request beat and updates the shadow registers, exactly
	// as the unit does when the beat moves from its input stage into the result register.
	function automatic result_t trap_unit_response(input item_t it);
		result_t r;
		word_t   active;
		word_t   st;
		r = '0;
		case (it.kind)
			KIND_READ: begin
				case (it.reg_select)
					SEL_MSTATUS: r.read_value = shadow_status;
					SEL_MIE:     r.read_value = shadow_enable;
					SEL_MIP:     r.read_value = shadow_pending;
					SEL_MEPC:    r.read_value = shadow_epc;
					SEL_MCAUSE:  r.read_value = shadow_cause;
					SEL_MTVEC:   r.read_value = shadow_vector;
					default:     r.read_value = '0;
				endcase
			end
			KIND_WRITE: begin
				case (it.reg_select)
					SEL_MSTATUS: shadow_status  = it.write_value;
					SEL_MIE:     shadow_enable  = it.write_value;
					SEL_MIP:     shadow_pending = it.write_value;
					SEL_MEPC:    shadow_epc     = it.write_value;
					SEL_MCAUSE:  shadow_cause   = it.write_value;
					SEL_MTVEC:   shadow_vector  = it.write_value;
					default:     ;
				endcase
			end
			KIND_CHECK: begin
				// A halted core drops the tick and reports nothing.
				if (it.core_running) begin
					if (it.timer_tick) begin
						shadow_pending[MIP_MTIP_BIT] = 1'b1;
						r.sync_needed = 1'b1;
					end
					if (shadow_status[MSTATUS_MIE_BIT]) begin
						active = shadow_pending & shadow_enable;
						// Timer wins over external when both are active.
						if (active[MIP_MTIP_BIT]) begin
							r.irq_valid = 1'b1;
							r.irq_cause = CAUSE_M_TIMER;
						end else if (active[MIP_MEIP_BIT]) begin
							r.irq_valid = 1'b1;
							r.irq_cause = CAUSE_M_EXT;
						end
						if (r.irq_valid) begin
							r.sync_needed = 1'b1;
						end
					end
				end
			end
			default: begin
				// Trap entry: only the two interrupt causes clear a pending bit.
				if (it.exc_cause == CAUSE_M_TIMER) begin
					shadow_pending[MIP_MTIP_BIT] = 1'b0;
				end else if (it.exc_cause == CAUSE_M_EXT) begin
					shadow_pending[MIP_MEIP_BIT] = 1'b0;
				end
				shadow_epc   = it.trap_pc;
				shadow_cause = it.exc_cause;
				st = shadow_status;
				st[MSTATUS_MPIE_BIT] = st[MSTATUS_MIE_BIT];
				st[MSTATUS_MIE_BIT]  = 1'b0;
				st[MSTATUS_MPP_HI:MSTATUS_MPP_LO] = 2'b11;
				shadow_status = st;
				r.handler_address = shadow_vector;
			end
		endcase
		return r;
	endfunction

	function automatic result_t resp_of(input word_t rd, input logic valid, input word_t cause,
			input logic sync, input word_t handler);
		result_t r;
		r.read_value      = rd;
		r.irq_valid       = valid;
		r.irq_cause       = cause;
		r.sync_needed     = sync;
		r.handler_address = handler;
		return r;
	endfunction

	function automatic stim_row_t stim_row(input kind_t k, input sel_t sel, input word_t wval,
			input logic tick, input logic run, input word_t cause, input word_t pc,
			input bit fixed, input result_t golden);
		stim_row_t row;
		row.item.kind         = k;
		row.item.reg_select   = sel;
		row.item.write_value  = wval;
		row.item.timer_tick   = tick;
		row.item.core_running = run;
		row.item.exc_cause    = cause;
		row.item.trap_pc      = pc;
		row.fixed             = fixed;
		row.golden            = golden;
		return row;
	endfunction

	// Random beat of the given kind: every other field, including the ones the kind ignores, gets random bits.
	function automatic stim_row_t random_beat(input kind_t k);
		stim_row_t row;
		row.item.kind         = k;
		row.item.reg_select   = sel_t'($urandom_range(0, 7));
		row.item.write_value  = $urandom;
		row.item.timer_tick   = 1'($urandom_range(0, 1));
		row.item.core_running = 1'($urandom_range(0, 1));
		row.item.exc_cause    = $urandom;
		row.item.trap_pc      = $urandom;
		row.fixed             = 1'b0;
		row.golden            = '0;
		return row;
	endfunction

	task automatic check_field(input string field, input word_t exp_val, input word_t got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, got_val);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Builds the whole stimulus list up front: the directed table first, then the random
	// part, which is mostly short interrupt scenarios with random content and some noise.
	initial begin : stimulus_build
		result_t   zero;
		stim_row_t row;
		int        pick;
		zero = '0;
		directed_rows = '{
			// mstatus reads zero out of reset, and so does an unmapped select.
			stim_row(KIND_READ,  SEL_MSTATUS, '0, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_READ,  SEL_NONE_HI, '0, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_WRITE, SEL_MTVEC, ALL_ONES, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_READ,  SEL_MTVEC, '0, 1'b0, 1'b0, '0, '0, 1'b1,
				resp_of(ALL_ONES, 1'b0, '0, 1'b0, '0)),
			stim_row(KIND_WRITE, SEL_MIE, ALL_ONES, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_WRITE, SEL_MSTATUS, MIE_MASK, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			// A halted core drops the tick, so mip stays clear.
			stim_row(KIND_CHECK, SEL_MSTATUS, '0, 1'b1, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_READ,  SEL_MIP, '0, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_CHECK, SEL_MSTATUS, '0, 1'b1, 1'b1, '0, '0, 1'b1,
				resp_of('0, 1'b1, CAUSE_M_TIMER, 1'b1, '0)),
			stim_row(KIND_TRAP,  SEL_MSTATUS, '0, 1'b0, 1'b0, CAUSE_M_TIMER, ALL_ONES, 1'b1,
				resp_of('0, 1'b0, '0, 1'b0, ALL_ONES)),
			stim_row(KIND_READ,  SEL_MSTATUS, '0, 1'b0, 1'b0, '0, '0, 1'b0, zero),
			stim_row(KIND_READ,  SEL_MIP, '0, 1'b0, 1'b0, '0, '0, 1'b0, zero),
			// External interrupt on its own, then its trap entry.
			stim_row(KIND_WRITE, SEL_MIP, MEIP_MASK, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_WRITE, SEL_MSTATUS, MIE_MASK, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_CHECK, SEL_MSTATUS, '0, 1'b0, 1'b1, '0, '0, 1'b1,
				resp_of('0, 1'b1, CAUSE_M_EXT, 1'b1, '0)),
			stim_row(KIND_TRAP,  SEL_MSTATUS, '0, 1'b0, 1'b0, CAUSE_M_EXT, '0, 1'b1,
				resp_of('0, 1'b0, '0, 1'b0, ALL_ONES)),
			// A cause that is neither interrupt leaves mip alone.
			stim_row(KIND_TRAP,  SEL_MSTATUS, '0, 1'b0, 1'b0, 32'h0000_0002, 32'h0000_1234,
				1'b0, zero),
			stim_row(KIND_READ,  SEL_MEPC, '0, 1'b0, 1'b0, '0, '0, 1'b0, zero),
			stim_row(KIND_READ,  SEL_MCAUSE, '0, 1'b0, 1'b0, '0, '0, 1'b0, zero),
			// Writes to an unmapped select are dropped.
			stim_row(KIND_WRITE, SEL_NONE_LO, ALL_ONES, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_READ,  SEL_NONE_LO, '0, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			// Tick with interrupts globally masked: sync but no interrupt.
			stim_row(KIND_CHECK, SEL_MSTATUS, '0, 1'b1, 1'b1, '0, '0, 1'b0, zero),
			stim_row(KIND_WRITE, SEL_MSTATUS, ALL_ONES, 1'b0, 1'b0, '0, '0, 1'b1, zero),
			stim_row(KIND_TRAP,  SEL_MSTATUS, '0, 1'b0, 1'b0, ALL_ONES, ALL_ONES, 1'b0, zero),
			stim_row(KIND_READ,  SEL_MSTATUS, '0, 1'b0, 1'b0, '0, '0, 1'b0, zero),
			stim_row(KIND_WRITE, SEL_MTVEC, '0, 1'b0, 1'b0, '0, '0, 1'b1, zero)
		};
		foreach (directed_rows[i]) begin
			pending_beats.push_back(directed_rows[i]);
		end
		while (pending_beats.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				// Enable, optionally force pending bits, check, take the trap, read back.
				row = random_beat(KIND_WRITE);
				row.item.reg_select = SEL_MSTATUS;
				if ($urandom_range(0, 3) != 0) begin
					row.item.write_value |= MIE_MASK;
				end
				pending_beats.push_back(row);
				row = random_beat(KIND_WRITE);
				row.item.reg_select = SEL_MIE;
				if ($urandom_range(0, 3) != 0) begin
					row.item.write_value |= ($urandom_range(0, 1) ? MTIP_MASK : MEIP_MASK);
				end
				pending_beats.push_back(row);
				if ($urandom_range(0, 2) == 0) begin
					row = random_beat(KIND_WRITE);
					row.item.reg_select = SEL_MIP;
					pending_beats.push_back(row);
				end
				row = random_beat(KIND_CHECK);
				row.item.core_running = ($urandom_range(0, 7) != 0);
				pending_beats.push_back(row);
				row = random_beat(KIND_TRAP);
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					row.item.exc_cause = CAUSE_M_TIMER;
				end else if (pick < 8) begin
					row.item.exc_cause = CAUSE_M_EXT;
				end
				pending_beats.push_back(row);
				pending_beats.push_back(random_beat(KIND_READ));
			end else begin
				pending_beats.push_back(random_beat(kind_t'($urandom_range(0, 3))));
			end
		end
		total_items = pending_beats.size();
	end

	// Reset, then wait for every beat to be sent and every response to be checked.
	initial begin
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.data    = '0;
		rsp_if.ready   = 1'b0;
		shadow_status  = '0;
		shadow_enable  = '0;
		shadow_pending = '0;
		shadow_epc     = '0;
		shadow_cause   = '0;
		shadow_vector  = '0;
		items_accepted = 0;
		results_seen   = 0;
		errors         = 0;
		gap_left       = 0;
		stall_left     = 0;
		hold_left      = 0;
		idle_cycles    = 0;
		quiet_tail     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (items_accepted != total_items || expected_responses.size() != 0) begin
			@(posedge clk);
		end
		// The TAIL_CYCLES tail after the last expected result lets any stray response beat
		// show up.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("** machine_mode_interrupt_unit: PASSED **");
		end else begin
			$display("** machine_mode_interrupt_unit: FAILED **");
		end
		$finish;
	end

	// Sender: offers the next beat as soon as the last one is taken, with random gaps
	// after some beats. The prediction is made at the edge on which the beat is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data  <= '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				items_accepted++;
				if (cur_row.fixed) begin
					void'(trap_unit_response(cur_row.item));
					expected_responses.push_back(cur_row.golden);
				end else begin
					expected_responses.push_back(trap_unit_response(cur_row.item));
				end
				if (!quiet_tail && $urandom_range(0, 3) == 0) begin
					gap_left = $urandom_range(1, 10);
				end
			end
			// Only move on once the beat on offer has been taken, so valid never drops early.
			if (!req_if.valid || req_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					cur_row    = pending_beats.pop_front();
					quiet_tail = (pending_beats.size() < QUIET_TAIL_ITEMS);
					req_if.valid <= 1'b1;
					req_if.data  <= cur_row.item;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every response beat against the oldest expectation. It stalls in
	// short random bursts, and once holds off for a long stretch so that both stages fill
	// and the unit has to push back on the sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (expected_responses.size() == 0) begin
					$display("%0t: response beat with nothing expected, expected none, actual %h",
						$time, rsp_if.data);
					errors++;
				end else begin
					want = expected_responses.pop_front();
					check_field("read_value", want.read_value, rsp_if.data.read_value);
					check_field("irq_valid", word_t'(want.irq_valid),
						word_t'(rsp_if.data.irq_valid));
					check_field("irq_cause", want.irq_cause, rsp_if.data.irq_cause);
					check_field("sync_needed", word_t'(want.sync_needed),
						word_t'(rsp_if.data.sync_needed));
					check_field("handler_address", want.handler_address,
						rsp_if.data.handler_address);
				end
				if (results_seen == HOLD_OFF_AT) begin
					hold_left = HOLD_OFF_CYCLES;
				end
			end
			if (quiet_tail) begin
				rsp_if.ready <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: any beat on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("** machine_mode_interrupt_unit: FAILED **");
				$finish;
			end
		end
	end

endmodule
